>>> src/gdh_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and mode codes for the grid distance heuristic block.
// Depends on nothing; every other file in src imports it.
package gdh_pkg;

	// Input coordinate and fixed-point format.
	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 8;
	localparam int MODE_BITS  = 3;
	localparam int DIST_BITS  = 29;

	// Derived datapath widths.
	localparam int SQ_BITS     = 2 * COORD_BITS;
	localparam int D2_BITS     = SQ_BITS + 1;
	localparam int RAD_BITS    = D2_BITS + 2 * FRAC_BITS;
	localparam int ROOT_BITS   = (RAD_BITS + 1) / 2;
	localparam int PROD_BITS   = 2 * D2_BITS;
	localparam int RHS_BITS    = PROD_BITS + 2 * FRAC_BITS;
	localparam int ACC_BITS    = RHS_BITS + 3;
	localparam int PART_BITS   = PROD_BITS + FRAC_BITS + 2;
	localparam int SIM_BITS    = FRAC_BITS + 1;
	localparam int BASE_BITS   = D2_BITS + FRAC_BITS;
	localparam int FIN_BITS    = (BASE_BITS + 1 > DIST_BITS) ? BASE_BITS + 1 : DIST_BITS;
	localparam int ITER_STAGES = (ROOT_BITS > SIM_BITS) ? ROOT_BITS : SIM_BITS;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_MANHATTAN = 3'd0,
		MODE_EUCLID    = 3'd1,
		MODE_SQ_EUCLID = 3'd2,
		MODE_CHEBYSHEV = 3'd3,
		MODE_COSINE    = 3'd4,
		MODE_OCTILE    = 3'd5
	} metric_mode_t;

	// Operands handed from the front end to the iterative stages.
	typedef struct packed {
		metric_mode_t          mode;
		logic [BASE_BITS-1:0]  base;
		logic [RAD_BITS-1:0]   rad;
		logic [PROD_BITS-1:0]  prod;
		logic [RHS_BITS-1:0]   rhs;
		logic                  zero_norm;
	} gdh_work_t;

	// Partial results handed from the iterative stages to the output stage.
	typedef struct packed {
		metric_mode_t          mode;
		logic [BASE_BITS-1:0]  base;
		logic [ROOT_BITS-1:0]  root;
		logic [SIM_BITS-1:0]   sim;
		logic                  zero_norm;
	} gdh_res_t;

endpackage

>>> src/gdh_front.sv
`timescale 1ns / 1ps
// Front end: differences, squares, sums and the two wide products, in four stages.
// Depends on gdh_pkg.
module gdh_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gdh_pkg::COORD_BITS-1:0] cur_x,
	input  logic [gdh_pkg::COORD_BITS-1:0] cur_y,
	input  logic [gdh_pkg::COORD_BITS-1:0] goal_x,
	input  logic [gdh_pkg::COORD_BITS-1:0] goal_y,
	input  gdh_pkg::metric_mode_t          mode,
	output logic                           work_valid,
	input  logic                           work_ready,
	output gdh_pkg::gdh_work_t             work
);
	import gdh_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic go1, go2, go3, go4;

	logic [COORD_BITS-1:0] cx_s1, cy_s1, gx_s1, gy_s1;
	logic [COORD_BITS-1:0] dx_s1, dy_s1, hi_s1, lo_s1;
	metric_mode_t          mode_s1;

	logic [SQ_BITS-1:0]    dx2_s2, dy2_s2, lo2_s2, cx2_s2, cy2_s2, gx2_s2, gy2_s2;
	logic [SQ_BITS-1:0]    pxx_s2, pyy_s2;
	logic [BASE_BITS-1:0]  pre_s2;
	metric_mode_t          mode_s2;

	logic [D2_BITS-1:0]    np_s3, ng_s3, dot_s3;
	logic [RAD_BITS-1:0]   rad_s3;
	logic [BASE_BITS-1:0]  base_s3;
	metric_mode_t          mode_s3;

	logic [PROD_BITS-1:0]  prod_s4;
	logic [RHS_BITS-1:0]   rhs_s4;
	logic [RAD_BITS-1:0]   rad_s4;
	logic [BASE_BITS-1:0]  base_s4;
	logic                  zero_s4;
	metric_mode_t          mode_s4;

	logic [COORD_BITS-1:0] dx_c, dy_c;
	logic [BASE_BITS-1:0]  pre_c;
	logic [D2_BITS-1:0]    d2_c, oct_c;

	// A stage loads when it is empty or its contents move on.
	assign go4      = !v_s4 || work_ready;
	assign go3      = !v_s3 || go4;
	assign go2      = !v_s2 || go3;
	assign go1      = !v_s1 || go2;
	assign in_ready = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (go1) v_s1 <= in_valid;
			if (go2) v_s2 <= v_s1;
			if (go3) v_s3 <= v_s2;
			if (go4) v_s4 <= v_s3;
		end
	end

	// Stage 1: absolute differences and their ordering.
	always_comb begin
		dx_c = (cur_x > goal_x) ? cur_x - goal_x : goal_x - cur_x;
		dy_c = (cur_y > goal_y) ? cur_y - goal_y : goal_y - cur_y;
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			cx_s1   <= cur_x;
			cy_s1   <= cur_y;
			gx_s1   <= goal_x;
			gy_s1   <= goal_y;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			hi_s1   <= (dx_c > dy_c) ? dx_c : dy_c;
			lo_s1   <= (dx_c > dy_c) ? dy_c : dx_c;
			mode_s1 <= mode;
		end
	end

	// Stage 2: the small products, and the results that need no product.
	always_comb begin
		case (mode_s1)
			MODE_MANHATTAN: pre_c = (BASE_BITS'(dx_s1) + BASE_BITS'(dy_s1)) << FRAC_BITS;
			MODE_CHEBYSHEV: pre_c = BASE_BITS'(hi_s1) << FRAC_BITS;
			MODE_OCTILE:    pre_c = BASE_BITS'(hi_s1 - lo_s1) << FRAC_BITS;
			default:        pre_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			dx2_s2  <= SQ_BITS'(dx_s1) * SQ_BITS'(dx_s1);
			dy2_s2  <= SQ_BITS'(dy_s1) * SQ_BITS'(dy_s1);
			lo2_s2  <= SQ_BITS'(lo_s1) * SQ_BITS'(lo_s1);
			cx2_s2  <= SQ_BITS'(cx_s1) * SQ_BITS'(cx_s1);
			cy2_s2  <= SQ_BITS'(cy_s1) * SQ_BITS'(cy_s1);
			gx2_s2  <= SQ_BITS'(gx_s1) * SQ_BITS'(gx_s1);
			gy2_s2  <= SQ_BITS'(gy_s1) * SQ_BITS'(gy_s1);
			pxx_s2  <= SQ_BITS'(cx_s1) * SQ_BITS'(gx_s1);
			pyy_s2  <= SQ_BITS'(cy_s1) * SQ_BITS'(gy_s1);
			pre_s2  <= pre_c;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: sums of squares, the norms, the dot product and the radicand.
	always_comb begin
		d2_c  = D2_BITS'(dx2_s2) + D2_BITS'(dy2_s2);
		oct_c = {lo2_s2, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			np_s3   <= D2_BITS'(cx2_s2) + D2_BITS'(cy2_s2);
			ng_s3   <= D2_BITS'(gx2_s2) + D2_BITS'(gy2_s2);
			dot_s3  <= D2_BITS'(pxx_s2) + D2_BITS'(pyy_s2);
			rad_s3  <= (mode_s2 == MODE_OCTILE) ? {oct_c, {(2 * FRAC_BITS){1'b0}}}
			                                    : {d2_c, {(2 * FRAC_BITS){1'b0}}};
			base_s3 <= (mode_s2 == MODE_SQ_EUCLID) ? BASE_BITS'(d2_c) << FRAC_BITS : pre_s2;
			mode_s3 <= mode_s2;
		end
	end

	// Stage 4: product of the norms and the scaled squared dot product.
	always_ff @(posedge clk) begin
		if (go4) begin
			prod_s4 <= PROD_BITS'(np_s3) * PROD_BITS'(ng_s3);
			rhs_s4  <= {PROD_BITS'(dot_s3) * PROD_BITS'(dot_s3), {(2 * FRAC_BITS){1'b0}}};
			zero_s4 <= (np_s3 == '0) || (ng_s3 == '0);
			rad_s4  <= rad_s3;
			base_s4 <= base_s3;
			mode_s4 <= mode_s3;
		end
	end

	assign work_valid     = v_s4;
	assign work.mode      = mode_s4;
	assign work.base      = base_s4;
	assign work.rad       = rad_s4;
	assign work.prod      = prod_s4;
	assign work.rhs       = rhs_s4;
	assign work.zero_norm = zero_s4;

`ifndef SYNTHESIS
	// A zero-norm flag must match a vanishing product of the norms.
	a_zero_prod: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (zero_s4 == (prod_s4 == '0)))
		else $error("zero-norm flag disagrees with the norm product");
	// A held stage 4 beat must still be there on the next cycle.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !work_ready |=> v_s4 && $stable(prod_s4) && $stable(rad_s4))
		else $error("stalled front-end beat was lost or altered");
`endif

endmodule

>>> src/gdh_iter.sv
`timescale 1ns / 1ps
// Iterative stages: a root bit per stage, a similarity bit in stages 0 to FRAC_BITS.
// Depends on gdh_pkg.
module gdh_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               work_valid,
	output logic               work_ready,
	input  gdh_pkg::gdh_work_t work,
	output logic               res_valid,
	input  logic               res_ready,
	output gdh_pkg::gdh_res_t  res
);
	import gdh_pkg::*;

	localparam int TW = RAD_BITS + 2;
	localparam int LAST = ITER_STAGES - 1;

	logic [ITER_STAGES-1:0] v_s;
	logic [ITER_STAGES:0]   go;

	metric_mode_t          mode_s [ITER_STAGES];
	logic [BASE_BITS-1:0]  base_s [ITER_STAGES];
	logic [ROOT_BITS-1:0]  root_s [ITER_STAGES];
	logic [RAD_BITS-1:0]   rem_s  [ITER_STAGES];
	logic [PROD_BITS-1:0]  prod_s [ITER_STAGES];
	logic [RHS_BITS-1:0]   rhs_s  [ITER_STAGES];
	logic [ACC_BITS-1:0]   acc_s  [ITER_STAGES];
	logic [PART_BITS-1:0]  part_s [ITER_STAGES];
	logic [SIM_BITS-1:0]   sim_s  [ITER_STAGES];
	logic                  zero_s [ITER_STAGES];

	assign go[ITER_STAGES] = res_ready;
	assign work_ready      = go[0];

	for (genvar j = 0; j < ITER_STAGES; j++) begin : g_stage
		metric_mode_t         mode_in;
		logic [BASE_BITS-1:0] base_in;
		logic [ROOT_BITS-1:0] root_in, root_nx;
		logic [RAD_BITS-1:0]  rem_in, rem_nx;
		logic [PROD_BITS-1:0] prod_in;
		logic [RHS_BITS-1:0]  rhs_in;
		logic [ACC_BITS-1:0]  acc_in, acc_nx;
		logic [PART_BITS-1:0] part_in, part_nx;
		logic [SIM_BITS-1:0]  sim_in, sim_nx;
		logic                 zero_in, v_in;

		assign go[j] = !v_s[j] || go[j+1];

		// Stage inputs: the front-end beat for the first stage, the previous stage otherwise.
		if (j == 0) begin : g_first
			assign v_in    = work_valid;
			assign mode_in = work.mode;
			assign base_in = work.base;
			assign root_in = '0;
			assign rem_in  = work.rad;
			assign prod_in = work.prod;
			assign rhs_in  = work.rhs;
			assign acc_in  = '0;
			assign part_in = '0;
			assign sim_in  = '0;
			assign zero_in = work.zero_norm;
		end else begin : g_next
			assign v_in    = v_s[j-1];
			assign mode_in = mode_s[j-1];
			assign base_in = base_s[j-1];
			assign root_in = root_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign prod_in = prod_s[j-1];
			assign rhs_in  = rhs_s[j-1];
			assign acc_in  = acc_s[j-1];
			assign part_in = part_s[j-1];
			assign sim_in  = sim_s[j-1];
			assign zero_in = zero_s[j-1];
		end

		// Square root, most significant bit first: try the bit against the remainder.
		if (j < ROOT_BITS) begin : g_root
			localparam int K = ROOT_BITS - 1 - j;
			logic [TW-1:0] term;
			logic          take;
			assign term    = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
			assign take    = TW'(rem_in) >= term;
			assign root_nx = take ? (root_in | (ROOT_BITS'(1) << K)) : root_in;
			assign rem_nx  = take ? RAD_BITS'(TW'(rem_in) - term) : rem_in;
		end else begin : g_root_pass
			assign root_nx = root_in;
			assign rem_nx  = rem_in;
		end

		// Similarity bit: keep s^2*prod and s*prod so that each trial is adds only.
		if (j < SIM_BITS) begin : g_sim
			localparam int B = FRAC_BITS - j;
			logic [ACC_BITS-1:0] cand;
			logic                take;
			assign cand    = acc_in + (ACC_BITS'(part_in) << (B + 1))
			               + (ACC_BITS'(prod_in) << (2 * B));
			assign take    = cand <= ACC_BITS'(rhs_in);
			assign acc_nx  = take ? cand : acc_in;
			assign part_nx = take ? part_in + (PART_BITS'(prod_in) << B) : part_in;
			assign sim_nx  = take ? (sim_in | (SIM_BITS'(1) << B)) : sim_in;
		end else begin : g_sim_pass
			assign acc_nx  = acc_in;
			assign part_nx = part_in;
			assign sim_nx  = sim_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (go[j]) begin
				v_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (go[j]) begin
				mode_s[j] <= mode_in;
				base_s[j] <= base_in;
				root_s[j] <= root_nx;
				rem_s[j]  <= rem_nx;
				prod_s[j] <= prod_in;
				rhs_s[j]  <= rhs_in;
				acc_s[j]  <= acc_nx;
				part_s[j] <= part_nx;
				sim_s[j]  <= sim_nx;
				zero_s[j] <= zero_in;
			end
		end
	end

	assign res_valid     = v_s[LAST];
	assign res.mode      = mode_s[LAST];
	assign res.base      = base_s[LAST];
	assign res.root      = root_s[LAST];
	assign res.sim       = sim_s[LAST];
	assign res.zero_norm = zero_s[LAST];

`ifndef SYNTHESIS
	// A finished square root leaves a remainder of at most twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST] |-> ({1'b0, rem_s[LAST]} <= ((RAD_BITS + 1)'(root_s[LAST]) << 1)))
		else $error("square root remainder out of range");
	// With both norms non-zero the similarity never exceeds one.
	a_sim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST] && !zero_s[LAST] |-> (sim_s[LAST] <= (SIM_BITS'(1) << FRAC_BITS)))
		else $error("similarity above one");
`endif

endmodule

>>> src/gdh_back.sv
`timescale 1ns / 1ps
// Output stage: picks the distance for the mode and holds it in the output register.
// Depends on gdh_pkg.
module gdh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	output logic                          res_ready,
	input  gdh_pkg::gdh_res_t             res,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gdh_pkg::DIST_BITS-1:0] distance
);
	import gdh_pkg::*;

	localparam logic [FIN_BITS-1:0] ONE = FIN_BITS'(1) << FRAC_BITS;

	logic                 out_v_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [FIN_BITS-1:0]  fin_c;
	logic [FIN_BITS-1:0]  sim_c;

	assign res_ready = !out_v_q || out_ready;

	// Final selection; unused modes arrive with a zero base.
	always_comb begin
		sim_c = (FIN_BITS'(res.sim) > ONE) ? ONE : FIN_BITS'(res.sim);
		case (res.mode)
			MODE_EUCLID:    fin_c = FIN_BITS'(res.root);
			MODE_OCTILE:    fin_c = FIN_BITS'(res.base) + FIN_BITS'(res.root);
			MODE_COSINE:    fin_c = res.zero_norm ? ONE : ONE - sim_c;
			default:        fin_c = FIN_BITS'(res.base);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			dist_q <= fin_c[DIST_BITS-1:0];
		end
	end

	assign out_valid = out_v_q;
	assign distance  = dist_q;

`ifndef SYNTHESIS
	// A cosine distance lies between zero and one.
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.mode == MODE_COSINE |=> (FIN_BITS'(dist_q) <= ONE))
		else $error("cosine distance above one");
	// Unused mode codes give a zero distance.
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.mode != MODE_MANHATTAN && res.mode != MODE_EUCLID
		&& res.mode != MODE_SQ_EUCLID && res.mode != MODE_CHEBYSHEV
		&& res.mode != MODE_COSINE && res.mode != MODE_OCTILE |=> dist_q == '0)
		else $error("unused mode gave a non-zero distance");
`endif

endmodule

>>> src/grid_distance_heuristic.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   cur_x, cur_y, goal_x, goal_y
// output    out_valid / out_ready distance
// config    cfg_we                cfg_data (metric_mode)
//
// One beat is accepted per cycle while the output is not stalled. A result passes through the
// front-end stages, the iterative stages and the output register before it is valid at the
// output; there are 4 + ITER_STAGES + 1 register stages in all.
// The latency is set by the square root, which resolves one root bit per stage.
// Reset clears all valid bits and sets the mode to Manhattan; no clearing pass.
// A stall at the output fills empty stages first, then holds every beat in place.
// Top level of the grid distance heuristic; depends on gdh_pkg, gdh_front, gdh_iter, gdh_back.
module grid_distance_heuristic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gdh_pkg::COORD_BITS-1:0] cur_x,
	input  logic [gdh_pkg::COORD_BITS-1:0] cur_y,
	input  logic [gdh_pkg::COORD_BITS-1:0] goal_x,
	input  logic [gdh_pkg::COORD_BITS-1:0] goal_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gdh_pkg::DIST_BITS-1:0]  distance,
	input  logic                           cfg_we,
	input  logic [gdh_pkg::MODE_BITS-1:0]  cfg_data
);
	import gdh_pkg::*;

	metric_mode_t metric_mode_q;
	logic         work_valid, work_ready, res_valid, res_ready;
	gdh_work_t    work;
	gdh_res_t     res;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_mode_q <= MODE_MANHATTAN;
		end else if (cfg_we) begin
			metric_mode_q <= metric_mode_t'(cfg_data);
		end
	end

	gdh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cur_x      (cur_x),
		.cur_y      (cur_y),
		.goal_x     (goal_x),
		.goal_y     (goal_y),
		.mode       (metric_mode_q),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.work       (work)
	);

	gdh_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (work_valid),
		.work_ready (work_ready),
		.work       (work),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	gdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.distance  (distance)
	);

endmodule
